// ----- hw/rtl/ctdi_pkg.sv -----
package ctdi_pkg;

    localparam int TABLE_SIZE_DEF = 4096;
    localparam int INDEX_BITS_DEF = 20;

    // Fixed widths of the port fields.
    localparam int FIELD_W = 20;
    localparam int POINT_W = 12;

    // Each table entry carries an epoch tag; tag zero marks an empty entry.
    localparam int EPOCH_W = 8;

    // Hash: three multiplies folded by XOR, then h ^= h >> 29, then modulo the table size.
    localparam int          HASH_W      = 64;
    localparam int          MIX_SHIFT   = 29;
    localparam int          REDUCE_BITS = 8;
    localparam logic [31:0] HASH_C0     = 32'h9E3779B1;
    localparam logic [31:0] HASH_C1     = 32'h85EBCA77;
    localparam logic [31:0] HASH_C2     = 32'hC2B2AE3D;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HSTART,
        ST_HWAIT,
        ST_LOOK_RD,
        ST_LOOK_CHK,
        ST_INS_DEC,
        ST_INS_RD,
        ST_INS_CHK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [POINT_W-1:0] point_index;
        logic               is_new_point;
        logic [FIELD_W-1:0] new_vertex;
        logic [FIELD_W-1:0] new_uv;
        logic [FIELD_W-1:0] new_normal;
        logic               overflow;
        logic               last_corner;
    } result_t;

endpackage

// ----- hw/rtl/ctdi_hash.sv -----
module ctdi_hash #(
    parameter int TABLE_SIZE = ctdi_pkg::TABLE_SIZE_DEF,
    parameter int COMP_W     = ctdi_pkg::FIELD_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [3*COMP_W-1:0]           key,
    output logic                          done,
    output logic [$clog2(TABLE_SIZE)-1:0] slot
);

    localparam int  SLOT_W    = $clog2(TABLE_SIZE);
    localparam bit  POW2      = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
    localparam int  STEP_MIX  = 3;
    localparam int  LAST_STEP = STEP_MIX +
        (POW2 ? 0 : ctdi_pkg::HASH_W / ctdi_pkg::REDUCE_BITS);
    localparam int  STEP_W    = $clog2(LAST_STEP + 1);

    logic                        busy_reg, busy_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic                        done_reg, done_next;
    logic [3*COMP_W-1:0]         key_reg, key_next;
    logic [ctdi_pkg::HASH_W-1:0] prod_reg, prod_next;
    logic [ctdi_pkg::HASH_W-1:0] acc_reg, acc_next;
    logic [ctdi_pkg::HASH_W-1:0] h_reg, h_next;
    logic [SLOT_W-1:0]           r_reg, r_next;

    logic [31:0]                 mul_a;
    logic [31:0]                 mul_b;
    logic [ctdi_pkg::HASH_W-1:0] mul_p;
    logic [ctdi_pkg::HASH_W-1:0] mix;
    logic [SLOT_W-1:0]           red_r;

    // One shared 32x32 multiplier, one key component per step.
    always_comb
    begin
        case (step_reg)
            STEP_W'(0):
            begin
                mul_a = 32'(key_reg[3*COMP_W-1 -: COMP_W]);
                mul_b = ctdi_pkg::HASH_C0;
            end
            STEP_W'(1):
            begin
                mul_a = 32'(key_reg[2*COMP_W-1 -: COMP_W]);
                mul_b = ctdi_pkg::HASH_C1;
            end
            default:
            begin
                mul_a = 32'(key_reg[COMP_W-1:0]);
                mul_b = ctdi_pkg::HASH_C2;
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
        mix   = acc_reg ^ prod_reg;
    end

    // Restoring reduction, eight hash bits per cycle from the top down.
    always_comb
    begin
        logic [SLOT_W:0] red_t;
        red_r = r_reg;
        for (int i = 0; i < ctdi_pkg::REDUCE_BITS; i++)
        begin
            red_t = {red_r, h_reg[ctdi_pkg::HASH_W-1-i]};
            if (red_t >= (SLOT_W+1)'(TABLE_SIZE))
            begin
                red_t = red_t - (SLOT_W+1)'(TABLE_SIZE);
            end
            red_r = red_t[SLOT_W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        key_next  = key_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        h_next    = h_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            key_next  = key;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + STEP_W'(1);
            if (step_reg < STEP_W'(STEP_MIX))
            begin
                prod_next = mul_p;
                if (step_reg != STEP_W'(0))
                begin
                    acc_next = mix;
                end
            end
            else if (step_reg == STEP_W'(STEP_MIX))
            begin
                h_next = mix ^ (mix >> ctdi_pkg::MIX_SHIFT);
                r_next = '0;
            end
            else
            begin
                r_next = red_r;
                h_next = h_reg << ctdi_pkg::REDUCE_BITS;
            end
            if (step_reg == STEP_W'(LAST_STEP))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        h_reg    <= h_next;
        r_reg    <= r_next;
    end

    assign done = done_reg;
    assign slot = POW2 ? h_reg[SLOT_W-1:0] : r_reg;

endmodule

// ----- hw/rtl/corner_triple_dedup_indexer.sv -----
// Channel | Handshake             | Payload                                  | One transfer
// --------+-----------------------+------------------------------------------+-------------------
// in      | in_valid / in_ready   | start_mesh, c0..c2 vertex/uv/normal      | one triangle
// out     | out_valid / out_ready | point_index, is_new_point, new_vertex,   | one corner result,
//         |                       | new_uv, new_normal, overflow, last_corner| three per triangle
//
// A triangle is taken only once the block has queued all three results of the previous
// one; each extra probe and each newly inserted corner adds a table read and check. The
// single-port table memory and the shared hash multiplier set the pace of a triangle.
// A table size that is not a power of two adds the restoring modulo steps to every corner.
// After reset the table is swept clear before the first input transfer;
// the same sweep runs on every 255th start_mesh, when the epoch tag wraps.
// Results go through a four-entry queue, so output stalls only hold the block once
// the queue is full.
module corner_triple_dedup_indexer #(
    parameter int TABLE_SIZE = ctdi_pkg::TABLE_SIZE_DEF,
    parameter int INDEX_BITS = ctdi_pkg::INDEX_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         start_mesh,
    input  logic [ctdi_pkg::FIELD_W-1:0] c0_vertex,
    input  logic [ctdi_pkg::FIELD_W-1:0] c0_uv,
    input  logic [ctdi_pkg::FIELD_W-1:0] c0_normal,
    input  logic [ctdi_pkg::FIELD_W-1:0] c1_vertex,
    input  logic [ctdi_pkg::FIELD_W-1:0] c1_uv,
    input  logic [ctdi_pkg::FIELD_W-1:0] c1_normal,
    input  logic [ctdi_pkg::FIELD_W-1:0] c2_vertex,
    input  logic [ctdi_pkg::FIELD_W-1:0] c2_uv,
    input  logic [ctdi_pkg::FIELD_W-1:0] c2_normal,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ctdi_pkg::POINT_W-1:0] point_index,
    output logic                         is_new_point,
    output logic [ctdi_pkg::FIELD_W-1:0] new_vertex,
    output logic [ctdi_pkg::FIELD_W-1:0] new_uv,
    output logic [ctdi_pkg::FIELD_W-1:0] new_normal,
    output logic                         overflow,
    output logic                         last_corner
);

    localparam int SLOT_W   = $clog2(TABLE_SIZE);
    localparam int CNT_W    = $clog2(TABLE_SIZE + 1);
    localparam int COMP_W   = (INDEX_BITS < ctdi_pkg::FIELD_W) ? INDEX_BITS : ctdi_pkg::FIELD_W;
    localparam int KEY_W    = 3 * COMP_W;
    localparam int ENTRY_W  = ctdi_pkg::EPOCH_W + KEY_W + SLOT_W;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);
    localparam logic [1:0] LAST_K = 2'd2;
    localparam logic [ctdi_pkg::EPOCH_W-1:0] EPOCH_FIRST = ctdi_pkg::EPOCH_W'(1);
    localparam logic [ctdi_pkg::EPOCH_W-1:0] EPOCH_MAX   = '1;

    ctdi_pkg::state_t state_reg, state_next;

    logic [ctdi_pkg::EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [SLOT_W-1:0]            clr_addr_reg, clr_addr_next;
    logic                         resume_reg, resume_next;
    logic [1:0]                   k_reg, k_next;

    logic [KEY_W-1:0]             key_reg   [3];
    logic [KEY_W-1:0]             key_next  [3];
    logic [SLOT_W-1:0]            slot_reg  [3];
    logic [SLOT_W-1:0]            slot_next [3];
    logic                         found_reg [3];
    logic                         found_next[3];
    logic [SLOT_W-1:0]            val_reg   [3];
    logic [SLOT_W-1:0]            val_next  [3];
    logic [SLOT_W-1:0]            addr_reg, addr_next;
    logic [CNT_W-1:0]             probe_reg, probe_next;
    ctdi_pkg::result_t            res_reg, res_next;

    ctdi_pkg::result_t            q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]           q_wr_reg, q_wr_next;
    logic [Q_PTR_W-1:0]           q_rd_reg, q_rd_next;
    logic [Q_CNT_W-1:0]           q_cnt_reg, q_cnt_next;

    logic [ENTRY_W-1:0]           mem [TABLE_SIZE];
    logic [ENTRY_W-1:0]           rd_data_reg;
    logic [ENTRY_W-1:0]           mem_wdata;
    logic [SLOT_W-1:0]            mem_addr;
    logic                         mem_we;
    logic                         mem_re;

    logic                         hash_start;
    logic                         hash_done;
    logic [SLOT_W-1:0]            hash_slot;

    logic [KEY_W-1:0]             key_cur;
    logic [1:0]                   k_inc;
    logic [SLOT_W-1:0]            addr_inc;
    logic                         ent_valid;
    logic                         ent_match;
    logic                         look_end;
    logic                         ins_hit;
    logic                         full;
    logic                         q_full;
    logic                         push;
    logic                         pop;
    ctdi_pkg::result_t            q_head;

    ctdi_hash #(
        .TABLE_SIZE (TABLE_SIZE),
        .COMP_W     (COMP_W)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key_reg[k_reg]),
        .done  (hash_done),
        .slot  (hash_slot)
    );

    // Entry layout: {epoch tag, key, point index}. A tag other than the current epoch
    // means the entry is empty.
    always_comb
    begin
        key_cur   = key_reg[k_reg];
        k_inc     = k_reg + 2'd1;
        addr_inc  = (addr_reg == SLOT_W'(TABLE_SIZE - 1)) ? '0 : addr_reg + SLOT_W'(1);
        ent_valid = (rd_data_reg[ENTRY_W-1 -: ctdi_pkg::EPOCH_W] == epoch_reg);
        ent_match = ent_valid && (rd_data_reg[SLOT_W +: KEY_W] == key_cur);
        look_end  = !ent_valid || ent_match || (probe_reg == CNT_W'(TABLE_SIZE - 1));
        ins_hit   = !ent_valid || ent_match;
        full      = (count_reg >= CNT_W'(TABLE_SIZE));
        q_full    = (q_cnt_reg == Q_CNT_W'(Q_DEPTH));
        pop       = out_valid && out_ready;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ctdi_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == SLOT_W'(TABLE_SIZE - 1))
                begin
                    state_next = resume_reg ? ctdi_pkg::ST_HSTART : ctdi_pkg::ST_IDLE;
                end
            end
            ctdi_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (start_mesh && (epoch_reg == EPOCH_MAX))
                    begin
                        state_next = ctdi_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ctdi_pkg::ST_HSTART;
                    end
                end
            end
            ctdi_pkg::ST_HSTART:
            begin
                state_next = ctdi_pkg::ST_HWAIT;
            end
            ctdi_pkg::ST_HWAIT:
            begin
                if (hash_done)
                begin
                    state_next = (k_reg == LAST_K) ? ctdi_pkg::ST_LOOK_RD : ctdi_pkg::ST_HSTART;
                end
            end
            ctdi_pkg::ST_LOOK_RD:
            begin
                state_next = ctdi_pkg::ST_LOOK_CHK;
            end
            ctdi_pkg::ST_LOOK_CHK:
            begin
                if (look_end && (k_reg == LAST_K))
                begin
                    state_next = ctdi_pkg::ST_INS_DEC;
                end
                else
                begin
                    state_next = ctdi_pkg::ST_LOOK_RD;
                end
            end
            ctdi_pkg::ST_INS_DEC:
            begin
                if (found_reg[k_reg] || full)
                begin
                    state_next = ctdi_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = ctdi_pkg::ST_INS_RD;
                end
            end
            ctdi_pkg::ST_INS_RD:
            begin
                state_next = ctdi_pkg::ST_INS_CHK;
            end
            ctdi_pkg::ST_INS_CHK:
            begin
                state_next = ins_hit ? ctdi_pkg::ST_EMIT : ctdi_pkg::ST_INS_RD;
            end
            ctdi_pkg::ST_EMIT:
            begin
                if (!q_full)
                begin
                    state_next = (k_reg == LAST_K) ? ctdi_pkg::ST_IDLE : ctdi_pkg::ST_INS_DEC;
                end
            end
            default:
            begin
                state_next = ctdi_pkg::ST_IDLE;
            end
        endcase
    end

    // Reads and writes of the table never fall in the same cycle, so a read always
    // sees every earlier insert.
    always_comb
    begin
        in_ready   = (state_reg == ctdi_pkg::ST_IDLE);
        hash_start = (state_reg == ctdi_pkg::ST_HSTART);
        mem_re     = (state_reg == ctdi_pkg::ST_LOOK_RD) || (state_reg == ctdi_pkg::ST_INS_RD);
        mem_we     = (state_reg == ctdi_pkg::ST_CLEAR) ||
                     ((state_reg == ctdi_pkg::ST_INS_CHK) && ins_hit);
        mem_addr   = (state_reg == ctdi_pkg::ST_CLEAR) ? clr_addr_reg : addr_reg;
        mem_wdata  = (state_reg == ctdi_pkg::ST_CLEAR) ? '0 :
                     {epoch_reg, key_cur, SLOT_W'(count_reg)};
        push       = (state_reg == ctdi_pkg::ST_EMIT) && !q_full;
    end

    always_comb
    begin
        epoch_next    = epoch_reg;
        count_next    = count_reg;
        clr_addr_next = clr_addr_reg;
        resume_next   = resume_reg;
        k_next        = k_reg;
        key_next      = key_reg;
        slot_next     = slot_reg;
        found_next    = found_reg;
        val_next      = val_reg;
        addr_next     = addr_reg;
        probe_next    = probe_reg;
        res_next      = res_reg;

        case (state_reg)
            ctdi_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == SLOT_W'(TABLE_SIZE - 1))
                begin
                    clr_addr_next = '0;
                    resume_next   = 1'b0;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + SLOT_W'(1);
                end
            end
            ctdi_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next[0] = {c0_vertex[COMP_W-1:0], c0_uv[COMP_W-1:0],
                                   c0_normal[COMP_W-1:0]};
                    key_next[1] = {c1_vertex[COMP_W-1:0], c1_uv[COMP_W-1:0],
                                   c1_normal[COMP_W-1:0]};
                    key_next[2] = {c2_vertex[COMP_W-1:0], c2_uv[COMP_W-1:0],
                                   c2_normal[COMP_W-1:0]};
                    k_next      = '0;
                    if (start_mesh)
                    begin
                        count_next = '0;
                        if (epoch_reg == EPOCH_MAX)
                        begin
                            epoch_next  = EPOCH_FIRST;
                            resume_next = 1'b1;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + ctdi_pkg::EPOCH_W'(1);
                        end
                    end
                end
            end
            ctdi_pkg::ST_HWAIT:
            begin
                if (hash_done)
                begin
                    slot_next[k_reg] = hash_slot;
                    if (k_reg == LAST_K)
                    begin
                        k_next     = '0;
                        addr_next  = slot_reg[0];
                        probe_next = '0;
                    end
                    else
                    begin
                        k_next = k_inc;
                    end
                end
            end
            ctdi_pkg::ST_LOOK_CHK:
            begin
                if (look_end)
                begin
                    found_next[k_reg] = ent_match;
                    val_next[k_reg]   = rd_data_reg[SLOT_W-1:0];
                    probe_next        = '0;
                    if (k_reg == LAST_K)
                    begin
                        k_next = '0;
                    end
                    else
                    begin
                        k_next    = k_inc;
                        addr_next = slot_reg[k_inc];
                    end
                end
                else
                begin
                    addr_next  = addr_inc;
                    probe_next = probe_reg + CNT_W'(1);
                end
            end
            ctdi_pkg::ST_INS_DEC:
            begin
                res_next             = '0;
                res_next.last_corner = (k_reg == LAST_K);
                if (found_reg[k_reg])
                begin
                    res_next.point_index = ctdi_pkg::POINT_W'(val_reg[k_reg]);
                end
                else if (full)
                begin
                    res_next.overflow = 1'b1;
                end
                else
                begin
                    addr_next = slot_reg[k_reg];
                end
            end
            ctdi_pkg::ST_INS_CHK:
            begin
                // The slot either is empty or holds the same triple inserted earlier in
                // this face; in both cases it takes the new point.
                if (ins_hit)
                begin
                    res_next.point_index  = ctdi_pkg::POINT_W'(count_reg);
                    res_next.is_new_point = 1'b1;
                    res_next.new_vertex   = ctdi_pkg::FIELD_W'(key_cur[3*COMP_W-1 -: COMP_W]);
                    res_next.new_uv       = ctdi_pkg::FIELD_W'(key_cur[2*COMP_W-1 -: COMP_W]);
                    res_next.new_normal   = ctdi_pkg::FIELD_W'(key_cur[COMP_W-1:0]);
                    count_next            = count_reg + CNT_W'(1);
                end
                else
                begin
                    addr_next = addr_inc;
                end
            end
            ctdi_pkg::ST_EMIT:
            begin
                if (!q_full)
                begin
                    k_next = (k_reg == LAST_K) ? 2'd0 : k_inc;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        q_wr_next  = push ? q_wr_reg + Q_PTR_W'(1) : q_wr_reg;
        q_rd_next  = pop ? q_rd_reg + Q_PTR_W'(1) : q_rd_reg;
        q_cnt_next = q_cnt_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
        q_head     = q_mem[q_rd_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ctdi_pkg::ST_CLEAR;
            epoch_reg    <= EPOCH_FIRST;
            count_reg    <= '0;
            clr_addr_reg <= '0;
            resume_reg   <= 1'b0;
            k_reg        <= '0;
            q_wr_reg     <= '0;
            q_rd_reg     <= '0;
            q_cnt_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            epoch_reg    <= epoch_next;
            count_reg    <= count_next;
            clr_addr_reg <= clr_addr_next;
            resume_reg   <= resume_next;
            k_reg        <= k_next;
            q_wr_reg     <= q_wr_next;
            q_rd_reg     <= q_rd_next;
            q_cnt_reg    <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        slot_reg  <= slot_next;
        found_reg <= found_next;
        val_reg   <= val_next;
        addr_reg  <= addr_next;
        probe_reg <= probe_next;
        res_reg   <= res_next;
        if (push)
        begin
            q_mem[q_wr_reg] <= res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    assign out_valid    = (q_cnt_reg != '0);
    assign point_index  = q_head.point_index;
    assign is_new_point = q_head.is_new_point;
    assign new_vertex   = q_head.new_vertex;
    assign new_uv       = q_head.new_uv;
    assign new_normal   = q_head.new_normal;
    assign overflow     = q_head.overflow;
    assign last_corner  = q_head.last_corner;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_SIZE))
        else $error("point counter beyond table size");

    a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("epoch tag collides with the empty mark");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && start_mesh) |=> (count_reg == '0))
        else $error("start_mesh did not clear the point counter");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overrun");

    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_new_point && overflow))
        else $error("result both new and overflowed");

endmodule
